// File: rtl/bcdec_pkg.sv
package bcdec_pkg;

  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;

  // Palette and index data for one block, B in [23:16], G in [15:8], R in [7:0]
  typedef struct packed {
    logic                  bc1;
    logic                  bc2;
    logic                  three;
    logic [3:0][23:0]      rgb;
    logic [7:0][7:0]       apal;
    logic [31:0]           cidx;
    logic [63:0]           ap;
  } pal_t;

  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
  endfunction

  // x <= 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd4682;
    return p[22:15];
  endfunction

  // x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

endpackage

// File: rtl/bcdec_palette.sv
module bcdec_palette
  import bcdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  fmt,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_alpha_part,
  input  logic [63:0] in_color_part,
  output logic        pal_valid,
  input  logic        pal_ready,
  output pal_t        pal
);

  logic             v1_r, v2_r;
  logic             s1_free, s2_free;

  logic [23:0]      c0_r, c0_nxt, c1_r, c1_nxt, half_r, half_nxt;
  logic [2:0][9:0]  sa_r, sa_nxt, sb_r, sb_nxt;
  logic [7:0]       a0_r, a1_r;
  logic             a0gt_r;
  logic [5:0][10:0] s7_r, s7_nxt;
  logic [3:0][10:0] s5_r, s5_nxt;
  logic             bc1_r, bc2_r, three_r;
  logic [31:0]      cidx_r;
  logic [63:0]      ap_r;
  pal_t             pal_r, pal_nxt;

  logic [7:0]       x0, x1, a0, a1;
  logic [8:0]       hs;

  assign s2_free  = !v2_r || pal_ready;
  assign s1_free  = !v1_r || s2_free;
  assign in_ready = s1_free;
  assign pal_valid = v2_r;
  assign pal       = pal_r;

  assign a0 = in_alpha_part[7:0];
  assign a1 = in_alpha_part[15:8];

  always_comb begin
    c0_nxt = expand565(in_color_part[15:0]);
    c1_nxt = expand565(in_color_part[31:16]);
    for (int ch = 0; ch < 3; ch++) begin
      x0 = c0_nxt[8*ch +: 8];
      x1 = c1_nxt[8*ch +: 8];
      sa_nxt[ch] = {1'b0, x0, 1'b0} + {2'b00, x1};
      sb_nxt[ch] = {2'b00, x0} + {1'b0, x1, 1'b0};
      hs = {1'b0, x0} + {1'b0, x1};
      half_nxt[8*ch +: 8] = hs[8:1];
    end
    for (int i = 1; i <= 6; i++) begin
      s7_nxt[i-1] = 11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
    end
    for (int i = 1; i <= 4; i++) begin
      s5_nxt[i-1] = 11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
    end
  end

  always_comb begin
    pal_nxt        = '0;
    pal_nxt.bc1    = bc1_r;
    pal_nxt.bc2    = bc2_r;
    pal_nxt.three  = three_r;
    pal_nxt.cidx   = cidx_r;
    pal_nxt.ap     = ap_r;
    pal_nxt.rgb[0] = c0_r;
    pal_nxt.rgb[1] = c1_r;
    for (int ch = 0; ch < 3; ch++) begin
      pal_nxt.rgb[2][8*ch +: 8] = three_r ? half_r[8*ch +: 8] : div3(sa_r[ch]);
      pal_nxt.rgb[3][8*ch +: 8] = three_r ? 8'd0 : div3(sb_r[ch]);
    end
    pal_nxt.apal[0] = a0_r;
    pal_nxt.apal[1] = a1_r;
    if (a0gt_r) begin
      for (int i = 0; i < 6; i++) begin
        pal_nxt.apal[i+2] = div7(s7_r[i]);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        pal_nxt.apal[i+2] = div5(s5_r[i]);
      end
      pal_nxt.apal[6] = 8'd0;
      pal_nxt.apal[7] = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_r <= in_valid;
      end
      if (s2_free) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      c0_r    <= c0_nxt;
      c1_r    <= c1_nxt;
      half_r  <= half_nxt;
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      a0_r    <= a0;
      a1_r    <= a1;
      a0gt_r  <= a0 > a1;
      s7_r    <= s7_nxt;
      s5_r    <= s5_nxt;
      bc1_r   <= fmt == FMT_BC1;
      bc2_r   <= fmt == FMT_BC2;
      three_r <= (fmt == FMT_BC1) && (in_color_part[15:0] <= in_color_part[31:16]);
      cidx_r  <= in_color_part[63:32];
      ap_r    <= in_alpha_part;
    end
    if (s2_free && v1_r) begin
      pal_r <= pal_nxt;
    end
  end

endmodule

// File: rtl/bcdec_rows.sv
module bcdec_rows
  import bcdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pal_valid,
  output logic        pal_ready,
  input  pal_t        pal,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_row_index,
  output logic        out_last_row,
  output logic [31:0] out_texel_a,
  output logic [31:0] out_texel_b,
  output logic [31:0] out_texel_c,
  output logic [31:0] out_texel_d
);

  logic             v3_r;
  pal_t             blk_r;
  logic [1:0]       row_r;
  logic             issue;

  logic             out_valid_r;
  logic [1:0]       row_index_r;
  logic             last_row_r;
  logic [3:0][31:0] texel_r, texel_nxt;

  logic [3:0]       t;
  logic [1:0]       sel;
  logic [7:0]       alpha;
  logic [5:0]       apos;
  logic [3:0]       nib;

  assign issue     = v3_r && (!out_valid_r || out_ready);
  assign pal_ready = !v3_r || (issue && row_r == 2'd3);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      t     = {row_r, 2'(c)};
      sel   = blk_r.cidx[{t, 1'b0} +: 2];
      nib   = blk_r.ap[{t, 2'b00} +: 4];
      apos  = 6'd16 + {2'b00, t} + {1'b0, t, 1'b0};
      if (blk_r.bc1) begin
        alpha = (blk_r.three && sel == 2'd3) ? 8'd0 : 8'd255;
      end else if (blk_r.bc2) begin
        alpha = {nib, nib};
      end else begin
        alpha = blk_r.apal[blk_r.ap[apos +: 3]];
      end
      texel_nxt[c] = {alpha, blk_r.rgb[sel]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      row_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pal_ready) begin
        v3_r  <= pal_valid;
        row_r <= 2'd0;
      end else if (issue) begin
        row_r <= row_r + 2'd1;
      end
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_ready && pal_valid) begin
      blk_r <= pal;
    end
    if (issue) begin
      row_index_r <= row_r;
      last_row_r  <= row_r == 2'd3;
      texel_r     <= texel_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = row_index_r;
  assign out_last_row  = last_row_r;
  assign out_texel_a   = texel_r[0];
  assign out_texel_b   = texel_r[1];
  assign out_texel_c   = texel_r[2];
  assign out_texel_d   = texel_r[3];

endmodule

// File: rtl/bc1_bc2_bc3_block_decoder.sv
// BC1/BC2/BC3 4x4 block decoder. Each input item is one compressed block
// (alpha part and color part, 64 bits each); it yields four row items, top
// row first, each with four RGBA8 texels packed R[7:0] G[15:8] B[23:16]
// A[31:24]. cfg_wr_data selects the format (0 BC1, 1 BC2, 2 or 3 BC3) and is
// sampled when a block enters; write it only while the decoder is empty.
// Blocks enter a two-stage palette pipeline back to back; the row stage then
// issues one row per cycle while out_ready does not stall it, four rows per
// block, and loads the next block as it issues the last row. Row 0 of a
// block passes the palette registers, the row stage and the output register.
module bc1_bc2_bc3_block_decoder
  import bcdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_alpha_part,
  input  logic [63:0] in_color_part,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_row_index,
  output logic        out_last_row,
  output logic [31:0] out_texel_a,
  output logic [31:0] out_texel_b,
  output logic [31:0] out_texel_c,
  output logic [31:0] out_texel_d
);

  logic [1:0] fmt_r;
  logic       pal_valid;
  logic       pal_ready;
  pal_t       pal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_BC1;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  bcdec_palette u_palette (
    .clk           (clk),
    .rst_n         (rst_n),
    .fmt           (fmt_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_alpha_part (in_alpha_part),
    .in_color_part (in_color_part),
    .pal_valid     (pal_valid),
    .pal_ready     (pal_ready),
    .pal           (pal)
  );

  bcdec_rows u_rows (
    .clk           (clk),
    .rst_n         (rst_n),
    .pal_valid     (pal_valid),
    .pal_ready     (pal_ready),
    .pal           (pal),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row),
    .out_texel_a   (out_texel_a),
    .out_texel_b   (out_texel_b),
    .out_texel_c   (out_texel_c),
    .out_texel_d   (out_texel_d)
  );

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_row) |=>
      (!out_valid || out_row_index == $past(out_row_index) + 2'd1))
    else $error("row items out of order");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_row) |=>
      (!out_valid || out_row_index == 2'd0))
    else $error("block does not start at row 0");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == 2'd3)))
    else $error("last row flag mismatch");

endmodule
